// ===== design/cpu6502_execute_datapath_assert.svh =====
// Assertion macros for the 6502 execute datapath.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef CPU6502_EXECUTE_DATAPATH_ASSERT_SVH
`define CPU6502_EXECUTE_DATAPATH_ASSERT_SVH

`ifndef SYNTHESIS
`define C6502EX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define C6502EX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define C6502EX_ASSERT(lbl, clk, rst_n, prop, msg)
`define C6502EX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/c6502ex_pkg.sv =====
// Constants for the 6502 execute datapath: opcodes, ALU groups, flags, reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c6502ex_pkg;

  localparam logic [7:0] A_RESET = 8'h00;
  localparam logic [7:0] X_RESET = 8'h00;
  localparam logic [7:0] Y_RESET = 8'h00;
  localparam logic [7:0] S_RESET = 8'hFD;
  localparam logic [7:0] P_RESET = 8'h24;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] PUSH_P_MASK = 8'h30;
  localparam logic [7:0] PULL_P_MASK = 8'hEF;
  localparam logic [7:0] B_MASK      = 8'h10;
  localparam logic [7:0] U_MASK      = 8'h20;

  // group one: opcode[1:0] == 2'b01, operation in opcode[7:5]
  localparam logic [1:0] GRP_ALU = 2'b01;
  localparam logic [2:0] ALU_ORA = 3'b000;
  localparam logic [2:0] ALU_AND = 3'b001;
  localparam logic [2:0] ALU_EOR = 3'b010;
  localparam logic [2:0] ALU_ADC = 3'b011;
  localparam logic [2:0] ALU_STA = 3'b100;
  localparam logic [2:0] ALU_LDA = 3'b101;
  localparam logic [2:0] ALU_CMP = 3'b110;
  localparam logic [2:0] ALU_SBC = 3'b111;
  localparam logic [7:0] OP_STA_IMM = 8'h89;

  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_SEC = 8'h38;
  localparam logic [7:0] OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8;
  localparam logic [7:0] OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8;
  localparam logic [7:0] OP_DEX = 8'hCA;
  localparam logic [7:0] OP_DEY = 8'h88;
  localparam logic [7:0] OP_INX = 8'hE8;
  localparam logic [7:0] OP_INY = 8'hC8;
  localparam logic [7:0] OP_TAX = 8'hAA;
  localparam logic [7:0] OP_TAY = 8'hA8;
  localparam logic [7:0] OP_TSX = 8'hBA;
  localparam logic [7:0] OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TXS = 8'h9A;
  localparam logic [7:0] OP_TYA = 8'h98;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_PHP = 8'h08;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_PLP = 8'h28;
  localparam logic [7:0] OP_BCC = 8'h90;
  localparam logic [7:0] OP_BCS = 8'hB0;
  localparam logic [7:0] OP_BNE = 8'hD0;
  localparam logic [7:0] OP_BEQ = 8'hF0;
  localparam logic [7:0] OP_BPL = 8'h10;
  localparam logic [7:0] OP_BMI = 8'h30;
  localparam logic [7:0] OP_BVC = 8'h50;
  localparam logic [7:0] OP_BVS = 8'h70;
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_BIT_ABS = 8'h2C;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_CPX_ZP  = 8'hE4;
  localparam logic [7:0] OP_CPX_ABS = 8'hEC;
  localparam logic [7:0] OP_CPY_IMM = 8'hC0;
  localparam logic [7:0] OP_CPY_ZP  = 8'hC4;
  localparam logic [7:0] OP_CPY_ABS = 8'hCC;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
  localparam logic [7:0] OP_LDX_ZPY = 8'hB6;
  localparam logic [7:0] OP_LDX_ABS = 8'hAE;
  localparam logic [7:0] OP_LDX_ABY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
  localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
  localparam logic [7:0] OP_LDY_ABS = 8'hAC;
  localparam logic [7:0] OP_LDY_ABX = 8'hBC;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STX_ZPY = 8'h96;
  localparam logic [7:0] OP_STX_ABS = 8'h8E;
  localparam logic [7:0] OP_STY_ZP  = 8'h84;
  localparam logic [7:0] OP_STY_ZPX = 8'h94;
  localparam logic [7:0] OP_STY_ABS = 8'h8C;
  localparam logic [7:0] OP_NOP     = 8'hEA;

endpackage

`default_nettype wire

// ===== design/cpu6502_execute_datapath.sv =====
// Execute datapath of a 6502: register file A, X, Y, S, P and the 8-bit ALU.
// Depends on c6502ex_pkg and cpu6502_execute_datapath_assert.svh.
//
// One opcode per transfer, with its operand byte already fetched. Throughput is one
// item per clock while out_ready is high. The item lands in an input register, then the
// ALU and flag logic execute it against A, X, Y, S, P combinationally and load the result
// register. A, X, Y, S and P are updated at that same edge, so the register outputs
// always show the state after the last delivered item. A stalled result holds the
// execute stage; the input register still takes one item behind it.
`timescale 1ns / 1ps
`default_nettype none

`include "cpu6502_execute_datapath_assert.svh"

module cpu6502_execute_datapath (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_opcode,
  input  wire logic [7:0] in_data_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_write_enable,
  output logic [7:0]      out_write_data,
  output logic [7:0]      out_stack_address,
  output logic [7:0]      out_a_value,
  output logic [7:0]      out_x_value,
  output logic [7:0]      out_y_value,
  output logic [7:0]      out_s_value,
  output logic [7:0]      out_p_value,
  output logic            out_branch_taken,
  output logic            out_illegal_opcode
);

  logic       in_valid_r;
  logic [7:0] op_r;
  logic [7:0] data_r;
  logic       out_valid_r;
  logic       we_r;
  logic [7:0] wd_r;
  logic [7:0] sa_r;
  logic       br_r;
  logic       ill_r;
  logic [7:0] reg_a_r;
  logic [7:0] reg_x_r;
  logic [7:0] reg_y_r;
  logic [7:0] reg_s_r;
  logic [7:0] reg_p_r;

  logic [7:0] reg_a_nxt;
  logic [7:0] reg_x_nxt;
  logic [7:0] reg_y_nxt;
  logic [7:0] reg_s_nxt;
  logic [7:0] reg_p_nxt;
  logic       we_nxt;
  logic [7:0] wd_nxt;
  logic [7:0] sa_nxt;
  logic       br_nxt;
  logic       ill_nxt;

  logic       exec;
  logic [7:0] adc_m;
  logic [8:0] adc_sum;
  logic       adc_v;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] s_inc;
  logic [7:0] s_dec;

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[c6502ex_pkg::FLAG_Z] = (v == 8'h00);
    q[c6502ex_pkg::FLAG_N] = v[7];
    return q;
  endfunction

  assign exec     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || exec;

  assign adc_m   = (op_r[7:5] == c6502ex_pkg::ALU_SBC) ? ~data_r : data_r;
  assign adc_sum = {1'b0, reg_a_r} + {1'b0, adc_m} + {8'h00, reg_p_r[c6502ex_pkg::FLAG_C]};
  assign adc_v   = ~(reg_a_r[7] ^ adc_m[7]) & (reg_a_r[7] ^ adc_sum[7]);

  always_comb begin
    case (op_r)
      c6502ex_pkg::OP_CPX_IMM, c6502ex_pkg::OP_CPX_ZP, c6502ex_pkg::OP_CPX_ABS: begin
        cmp_reg = reg_x_r;
      end
      c6502ex_pkg::OP_CPY_IMM, c6502ex_pkg::OP_CPY_ZP, c6502ex_pkg::OP_CPY_ABS: begin
        cmp_reg = reg_y_r;
      end
      default: begin
        cmp_reg = reg_a_r;
      end
    endcase
  end

  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, data_r};
  assign s_inc    = reg_s_r + 8'h01;
  assign s_dec    = reg_s_r - 8'h01;

  always_comb begin
    reg_a_nxt = reg_a_r;
    reg_x_nxt = reg_x_r;
    reg_y_nxt = reg_y_r;
    reg_s_nxt = reg_s_r;
    reg_p_nxt = reg_p_r;
    we_nxt    = 1'b0;
    wd_nxt    = 8'h00;
    sa_nxt    = 8'h00;
    br_nxt    = 1'b0;
    ill_nxt   = 1'b0;
    if (op_r[1:0] == c6502ex_pkg::GRP_ALU) begin
      case (op_r[7:5])
        c6502ex_pkg::ALU_ORA: begin
          reg_a_nxt = reg_a_r | data_r;
          reg_p_nxt = with_nz(reg_p_r, reg_a_r | data_r);
        end
        c6502ex_pkg::ALU_AND: begin
          reg_a_nxt = reg_a_r & data_r;
          reg_p_nxt = with_nz(reg_p_r, reg_a_r & data_r);
        end
        c6502ex_pkg::ALU_EOR: begin
          reg_a_nxt = reg_a_r ^ data_r;
          reg_p_nxt = with_nz(reg_p_r, reg_a_r ^ data_r);
        end
        c6502ex_pkg::ALU_STA: begin
          if (op_r != c6502ex_pkg::OP_STA_IMM) begin
            we_nxt = 1'b1;
            wd_nxt = reg_a_r;
          end
        end
        c6502ex_pkg::ALU_LDA: begin
          reg_a_nxt = data_r;
          reg_p_nxt = with_nz(reg_p_r, data_r);
        end
        c6502ex_pkg::ALU_CMP: begin
          reg_p_nxt = with_nz(reg_p_r, cmp_diff[7:0]);
          reg_p_nxt[c6502ex_pkg::FLAG_C] = ~cmp_diff[8];
        end
        default: begin
          // ADC and SBC share the adder; SBC feeds the inverted operand
          reg_a_nxt = adc_sum[7:0];
          reg_p_nxt = with_nz(reg_p_r, adc_sum[7:0]);
          reg_p_nxt[c6502ex_pkg::FLAG_C] = adc_sum[8];
          reg_p_nxt[c6502ex_pkg::FLAG_V] = adc_v;
        end
      endcase
    end else begin
      case (op_r)
        c6502ex_pkg::OP_CLC: reg_p_nxt[c6502ex_pkg::FLAG_C] = 1'b0;
        c6502ex_pkg::OP_SEC: reg_p_nxt[c6502ex_pkg::FLAG_C] = 1'b1;
        c6502ex_pkg::OP_CLD: reg_p_nxt[c6502ex_pkg::FLAG_D] = 1'b0;
        c6502ex_pkg::OP_SED: reg_p_nxt[c6502ex_pkg::FLAG_D] = 1'b1;
        c6502ex_pkg::OP_CLI: reg_p_nxt[c6502ex_pkg::FLAG_I] = 1'b0;
        c6502ex_pkg::OP_SEI: reg_p_nxt[c6502ex_pkg::FLAG_I] = 1'b1;
        c6502ex_pkg::OP_CLV: reg_p_nxt[c6502ex_pkg::FLAG_V] = 1'b0;
        c6502ex_pkg::OP_DEX: begin
          reg_x_nxt = reg_x_r - 8'h01;
          reg_p_nxt = with_nz(reg_p_r, reg_x_r - 8'h01);
        end
        c6502ex_pkg::OP_DEY: begin
          reg_y_nxt = reg_y_r - 8'h01;
          reg_p_nxt = with_nz(reg_p_r, reg_y_r - 8'h01);
        end
        c6502ex_pkg::OP_INX: begin
          reg_x_nxt = reg_x_r + 8'h01;
          reg_p_nxt = with_nz(reg_p_r, reg_x_r + 8'h01);
        end
        c6502ex_pkg::OP_INY: begin
          reg_y_nxt = reg_y_r + 8'h01;
          reg_p_nxt = with_nz(reg_p_r, reg_y_r + 8'h01);
        end
        c6502ex_pkg::OP_TAX: begin
          reg_x_nxt = reg_a_r;
          reg_p_nxt = with_nz(reg_p_r, reg_a_r);
        end
        c6502ex_pkg::OP_TAY: begin
          reg_y_nxt = reg_a_r;
          reg_p_nxt = with_nz(reg_p_r, reg_a_r);
        end
        c6502ex_pkg::OP_TSX: begin
          reg_x_nxt = reg_s_r;
          reg_p_nxt = with_nz(reg_p_r, reg_s_r);
        end
        c6502ex_pkg::OP_TXA: begin
          reg_a_nxt = reg_x_r;
          reg_p_nxt = with_nz(reg_p_r, reg_x_r);
        end
        c6502ex_pkg::OP_TXS: reg_s_nxt = reg_x_r;
        c6502ex_pkg::OP_TYA: begin
          reg_a_nxt = reg_y_r;
          reg_p_nxt = with_nz(reg_p_r, reg_y_r);
        end
        c6502ex_pkg::OP_PHA: begin
          we_nxt    = 1'b1;
          wd_nxt    = reg_a_r;
          sa_nxt    = reg_s_r;
          reg_s_nxt = s_dec;
        end
        c6502ex_pkg::OP_PHP: begin
          we_nxt    = 1'b1;
          wd_nxt    = reg_p_r | c6502ex_pkg::PUSH_P_MASK;
          sa_nxt    = reg_s_r;
          reg_s_nxt = s_dec;
        end
        c6502ex_pkg::OP_PLA: begin
          reg_s_nxt = s_inc;
          sa_nxt    = s_inc;
          reg_a_nxt = data_r;
          reg_p_nxt = with_nz(reg_p_r, data_r);
        end
        c6502ex_pkg::OP_PLP: begin
          reg_s_nxt = s_inc;
          sa_nxt    = s_inc;
          reg_p_nxt = (data_r & c6502ex_pkg::PULL_P_MASK) | (reg_p_r & c6502ex_pkg::B_MASK)
                      | c6502ex_pkg::U_MASK;
        end
        c6502ex_pkg::OP_BCC: br_nxt = ~reg_p_r[c6502ex_pkg::FLAG_C];
        c6502ex_pkg::OP_BCS: br_nxt = reg_p_r[c6502ex_pkg::FLAG_C];
        c6502ex_pkg::OP_BNE: br_nxt = ~reg_p_r[c6502ex_pkg::FLAG_Z];
        c6502ex_pkg::OP_BEQ: br_nxt = reg_p_r[c6502ex_pkg::FLAG_Z];
        c6502ex_pkg::OP_BPL: br_nxt = ~reg_p_r[c6502ex_pkg::FLAG_N];
        c6502ex_pkg::OP_BMI: br_nxt = reg_p_r[c6502ex_pkg::FLAG_N];
        c6502ex_pkg::OP_BVC: br_nxt = ~reg_p_r[c6502ex_pkg::FLAG_V];
        c6502ex_pkg::OP_BVS: br_nxt = reg_p_r[c6502ex_pkg::FLAG_V];
        c6502ex_pkg::OP_BIT_ZP, c6502ex_pkg::OP_BIT_ABS: begin
          reg_p_nxt[c6502ex_pkg::FLAG_Z] = ((data_r & reg_a_r) == 8'h00);
          reg_p_nxt[c6502ex_pkg::FLAG_V] = data_r[6];
          reg_p_nxt[c6502ex_pkg::FLAG_N] = data_r[7];
        end
        c6502ex_pkg::OP_CPX_IMM, c6502ex_pkg::OP_CPX_ZP, c6502ex_pkg::OP_CPX_ABS,
        c6502ex_pkg::OP_CPY_IMM, c6502ex_pkg::OP_CPY_ZP, c6502ex_pkg::OP_CPY_ABS: begin
          reg_p_nxt = with_nz(reg_p_r, cmp_diff[7:0]);
          reg_p_nxt[c6502ex_pkg::FLAG_C] = ~cmp_diff[8];
        end
        c6502ex_pkg::OP_LDX_IMM, c6502ex_pkg::OP_LDX_ZP, c6502ex_pkg::OP_LDX_ZPY,
        c6502ex_pkg::OP_LDX_ABS, c6502ex_pkg::OP_LDX_ABY: begin
          reg_x_nxt = data_r;
          reg_p_nxt = with_nz(reg_p_r, data_r);
        end
        c6502ex_pkg::OP_LDY_IMM, c6502ex_pkg::OP_LDY_ZP, c6502ex_pkg::OP_LDY_ZPX,
        c6502ex_pkg::OP_LDY_ABS, c6502ex_pkg::OP_LDY_ABX: begin
          reg_y_nxt = data_r;
          reg_p_nxt = with_nz(reg_p_r, data_r);
        end
        c6502ex_pkg::OP_STX_ZP, c6502ex_pkg::OP_STX_ZPY, c6502ex_pkg::OP_STX_ABS: begin
          we_nxt = 1'b1;
          wd_nxt = reg_x_r;
        end
        c6502ex_pkg::OP_STY_ZP, c6502ex_pkg::OP_STY_ZPX, c6502ex_pkg::OP_STY_ABS: begin
          we_nxt = 1'b1;
          wd_nxt = reg_y_r;
        end
        c6502ex_pkg::OP_NOP: begin
        end
        default: ill_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      reg_a_r     <= c6502ex_pkg::A_RESET;
      reg_x_r     <= c6502ex_pkg::X_RESET;
      reg_y_r     <= c6502ex_pkg::Y_RESET;
      reg_s_r     <= c6502ex_pkg::S_RESET;
      reg_p_r     <= c6502ex_pkg::P_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
        reg_a_r     <= reg_a_nxt;
        reg_x_r     <= reg_x_nxt;
        reg_y_r     <= reg_y_nxt;
        reg_s_r     <= reg_s_nxt;
        reg_p_r     <= reg_p_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      data_r <= in_data_in;
    end
    if (exec) begin
      we_r  <= we_nxt;
      wd_r  <= wd_nxt;
      sa_r  <= sa_nxt;
      br_r  <= br_nxt;
      ill_r <= ill_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_write_enable   = we_r;
  assign out_write_data     = wd_r;
  assign out_stack_address  = sa_r;
  assign out_a_value        = reg_a_r;
  assign out_x_value        = reg_x_r;
  assign out_y_value        = reg_y_r;
  assign out_s_value        = reg_s_r;
  assign out_p_value        = reg_p_r;
  assign out_branch_taken   = br_r;
  assign out_illegal_opcode = ill_r;

  `C6502EX_ASSERT_NEXT(a_regs_hold, clk, rst_n, !exec,
    $stable(reg_a_r) && $stable(reg_x_r) && $stable(reg_y_r)
      && $stable(reg_s_r) && $stable(reg_p_r),
    "register file changed without an executed item")
  `C6502EX_ASSERT(a_p_fixed_bits, clk, rst_n,
    reg_p_r[c6502ex_pkg::FLAG_U] && !reg_p_r[c6502ex_pkg::FLAG_B],
    "status bit 5 cleared or bit 4 set")
  `C6502EX_ASSERT(a_illegal_quiet, clk, rst_n,
    !(out_valid_r && ill_r && (we_r || br_r)),
    "illegal opcode produced a write or branch")
  `C6502EX_ASSERT_NEXT(a_exec_delivers, clk, rst_n, exec, out_valid_r,
    "executed item has no result")
  `C6502EX_ASSERT(a_stall_holds_item, clk, rst_n, !(in_valid_r && !exec && in_ready),
    "input register open while its item is stalled")

endmodule

`default_nettype wire
